[hdl/dht_pkg.sv]
package dht_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 8;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture an accepted item
    logic probe_en;  // walk the slots for a lookup or insert
    logic sweep_en;  // write empty entries, one slot a cycle
    logic out_load;  // move the finished result into the output register
  } dht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic probe_end;   // probe found its slot or ran over every slot
    logic sweep_last;  // sweep writes the last slot this cycle
  } dht_sts_t;

endpackage

[hdl/dht_datapath.sv]
module dht_datapath #(
  parameter int unsigned TABLE_ENTRIES = dht_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dht_pkg::dht_cmd_t                cmd_i,
  output dht_pkg::dht_sts_t                sts_o,
  input  logic [dht_pkg::FUNC_W-1:0]       func_i,
  input  logic [dht_pkg::WORD_W-1:0]       hash_word0_i,
  input  logic [dht_pkg::WORD_W-1:0]       hash_word1_i,
  input  logic [dht_pkg::WORD_W-1:0]       hash_word2_i,
  input  logic [dht_pkg::WORD_W-1:0]       hash_word3_i,
  input  logic [dht_pkg::WORD_W-1:0]       id_high_i,
  input  logic [dht_pkg::WORD_W-1:0]       id_low_i,
  output logic [dht_pkg::STATUS_W-1:0]     status_o,
  output logic [dht_pkg::WORD_W-1:0]       found_id_high_o,
  output logic [dht_pkg::WORD_W-1:0]       found_id_low_o,
  output logic [dht_pkg::SLOT_W-1:0]       slot_index_o
);
  import dht_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RED_W = 21;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] ALL_SLOTS = CNT_W'(TABLE_ENTRIES);

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
    logic [WORD_W-1:0] idh;
    logic [WORD_W-1:0] idl;
  } entry_t;

  // XOR of digest bytes 0..3, reduced modulo the table size by
  // conditional subtraction of shifted multiples
  function automatic logic [IDX_W-1:0] home_slot(input logic [WORD_W-1:0] w);
    logic [RED_W-1:0] r;
    logic [RED_W-1:0] m;
    r = RED_W'(w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24]);
    for (int k = 7; k >= 0; k--) begin
      m = RED_W'(TABLE_ENTRIES) << k;
      if (r >= m) begin
        r = r - m;
      end
    end
    return IDX_W'(r);
  endfunction

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q;

  logic [FUNC_W-1:0]   func_q;
  logic [WORD_W-1:0]   w0_q, w1_q, w2_q, w3_q, idh_q, idl_q;
  logic [IDX_W-1:0]    addr_q, addr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]    rd_slot_q;
  logic                issue;
  logic                key_hit;
  logic                found;
  logic                ins_wr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  entry_t              mem_wd;
  logic [IDX_W-1:0]    addr_inc;

  logic [STATUS_W-1:0] res_status_q;
  logic [WORD_W-1:0]   res_idh_q, res_idl_q;
  logic [SLOT_W-1:0]   res_slot_q;

  assign addr_inc = (addr_q == LAST_SLOT) ? '0 : addr_q + 1'b1;
  assign issue    = cmd_i.probe_en && (cnt_q != ALL_SLOTS);

  assign key_hit = (rd_q.k0 == w0_q) && (rd_q.k1 == w1_q) &&
                   (rd_q.k2 == w2_q) && (rd_q.k3 == w3_q);

  always_comb begin
    found = 1'b0;
    if (cmd_i.probe_en && rd_vld_q) begin
      if (func_q == FUNC_INSERT) begin
        found = !rd_q.vld;
      end else begin
        found = rd_q.vld && key_hit;
      end
    end
  end

  assign ins_wr = found && (func_q == FUNC_INSERT);

  assign sts_o.probe_end  = found || ((cnt_q == ALL_SLOTS) && !rd_vld_q);
  assign sts_o.sweep_last = cmd_i.sweep_en && (addr_q == LAST_SLOT);

  always_comb begin
    mem_we = cmd_i.sweep_en || ins_wr;
    mem_wa = cmd_i.sweep_en ? addr_q : rd_slot_q;
    mem_wd = '0;
    if (!cmd_i.sweep_en) begin
      mem_wd.vld = 1'b1;
      mem_wd.k0  = w0_q;
      mem_wd.k1  = w1_q;
      mem_wd.k2  = w2_q;
      mem_wd.k3  = w3_q;
      mem_wd.idh = idh_q;
      mem_wd.idl = idl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[addr_q];
  end

  always_comb begin
    addr_d   = addr_q;
    cnt_d    = cnt_q;
    rd_vld_d = issue;
    if (cmd_i.load) begin
      addr_d   = (func_i == FUNC_CLEAR) ? '0 : home_slot(hash_word0_i);
      cnt_d    = '0;
      rd_vld_d = 1'b0;
    end else if (issue) begin
      addr_d = addr_inc;
      cnt_d  = cnt_q + 1'b1;
    end else if (cmd_i.sweep_en) begin
      addr_d = addr_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_slot_q <= addr_q;
    end
    if (cmd_i.load) begin
      func_q     <= func_i;
      w0_q       <= hash_word0_i;
      w1_q       <= hash_word1_i;
      w2_q       <= hash_word2_i;
      w3_q       <= hash_word3_i;
      idh_q      <= id_high_i;
      idl_q      <= id_low_i;
      res_idh_q  <= '0;
      res_idl_q  <= '0;
      res_slot_q <= '0;
      case (func_i)
        FUNC_INSERT: res_status_q <= STAT_FULL;
        FUNC_CLEAR:  res_status_q <= STAT_CLEARED;
        default:     res_status_q <= STAT_MISS;
      endcase
    end else if (found) begin
      res_slot_q <= SLOT_W'(rd_slot_q);
      if (func_q == FUNC_INSERT) begin
        res_status_q <= STAT_INSERTED;
      end else begin
        res_status_q <= STAT_HIT;
        res_idh_q    <= rd_q.idh;
        res_idl_q    <= rd_q.idl;
      end
    end
    if (cmd_i.out_load) begin
      status_o        <= res_status_q;
      found_id_high_o <= res_idh_q;
      found_id_low_o  <= res_idl_q;
      slot_index_o    <= res_slot_q;
    end
  end

endmodule

[hdl/dht_ctrl.sv]
module dht_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dht_pkg::FUNC_W-1:0]  func_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  dht_pkg::dht_sts_t           sts_i,
  output dht_pkg::dht_cmd_t           cmd_o
);
  import dht_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PROBE,
    ST_SWEEP,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.probe_en = (state_q == ST_PROBE);
    cmd_o.sweep_en = (state_q == ST_INIT) || (state_q == ST_SWEEP);
    cmd_o.out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          if (sts_i.sweep_last) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            in_ready_q <= 1'b0;
            case (func_i)
              FUNC_LOOKUP: state_q <= ST_PROBE;
              FUNC_INSERT: state_q <= ST_PROBE;
              FUNC_CLEAR:  state_q <= ST_SWEEP;
              default:     state_q <= ST_DONE;
            endcase
          end
        end
        ST_PROBE: begin
          if (sts_i.probe_end) begin
            state_q <= ST_DONE;
          end
        end
        ST_SWEEP: begin
          if (sts_i.sweep_last) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (cmd_o.out_load) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= ST_INIT;
          in_ready_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

[hdl/dedup_hash_table_core.sv]
// channel  direction  handshake                payload
// in       input      in_valid_i / in_ready_o  func_i, hash_word0..3_i, id_high_i, id_low_i
// out      output     out_valid_o / out_ready_i status_o, found_id_high_o, found_id_low_o,
//                                              slot_index_o
//
// One item at a time. Lookup and insert read one slot per cycle from the slot
// memory, so a miss or a full table walks every slot, while a hit or insert
// stops at its slot. Clear sweeps the memory at one slot a cycle. Bad function
// codes go straight to the done state and report a miss.
// After reset the same sweep runs over every slot before in_ready_o
// rises. A stalled output holds the finished result; the next item is taken
// meanwhile and waits in its last state until the output register is free.
module dedup_hash_table_core #(
  parameter int unsigned TABLE_ENTRIES = dht_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dht_pkg::FUNC_W-1:0]   func_i,
  input  logic [dht_pkg::WORD_W-1:0]   hash_word0_i,
  input  logic [dht_pkg::WORD_W-1:0]   hash_word1_i,
  input  logic [dht_pkg::WORD_W-1:0]   hash_word2_i,
  input  logic [dht_pkg::WORD_W-1:0]   hash_word3_i,
  input  logic [dht_pkg::WORD_W-1:0]   id_high_i,
  input  logic [dht_pkg::WORD_W-1:0]   id_low_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dht_pkg::STATUS_W-1:0] status_o,
  output logic [dht_pkg::WORD_W-1:0]   found_id_high_o,
  output logic [dht_pkg::WORD_W-1:0]   found_id_low_o,
  output logic [dht_pkg::SLOT_W-1:0]   slot_index_o
);
  import dht_pkg::*;

  dht_cmd_t cmd;
  dht_sts_t sts;

  dht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dht_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .hash_word0_i    (hash_word0_i),
    .hash_word1_i    (hash_word1_i),
    .hash_word2_i    (hash_word2_i),
    .hash_word3_i    (hash_word3_i),
    .id_high_i       (id_high_i),
    .id_low_i        (id_low_i),
    .status_o        (status_o),
    .found_id_high_o (found_id_high_o),
    .found_id_low_o  (found_id_low_o),
    .slot_index_o    (slot_index_o)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import dht_pkg::*;

  localparam int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned TAIL_ITEMS = 60;

  typedef logic [3:0][WORD_W-1:0] digest_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    digest_t           digest;
    logic [WORD_W-1:0] id_hi;
    logic [WORD_W-1:0] id_lo;
  } dedup_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   id_hi;
    logic [WORD_W-1:0]   id_lo;
    logic [SLOT_W-1:0]   slot;
  } dedup_rsp_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i          = '0;
  logic [WORD_W-1:0]   hash_word0_i    = '0;
  logic [WORD_W-1:0]   hash_word1_i    = '0;
  logic [WORD_W-1:0]   hash_word2_i    = '0;
  logic [WORD_W-1:0]   hash_word3_i    = '0;
  logic [WORD_W-1:0]   id_high_i       = '0;
  logic [WORD_W-1:0]   id_low_i        = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [WORD_W-1:0]   found_id_high_o;
  logic [WORD_W-1:0]   found_id_low_o;
  logic [SLOT_W-1:0]   slot_index_o;

  dedup_req_t  pending_q[$];
  dedup_rsp_t  lookup_answers_q[$];
  digest_t     digest_pool[$];
  int unsigned inserts_since_clear = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  logic        tail_phase = 1'b0;
  dedup_req_t  taken_req;
  dedup_rsp_t  got_rsp;
  dedup_rsp_t  want_rsp;

  // mirror of the slot memory
  logic              slot_valid [TABLE_ENTRIES];
  digest_t           slot_digest[TABLE_ENTRIES];
  logic [WORD_W-1:0] slot_id_hi [TABLE_ENTRIES];
  logic [WORD_W-1:0] slot_id_lo [TABLE_ENTRIES];

  dedup_hash_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .hash_word0_i,
    .hash_word1_i,
    .hash_word2_i,
    .hash_word3_i,
    .id_high_i,
    .id_low_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .found_id_high_o,
    .found_id_low_o,
    .slot_index_o
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Walk the slots from the home bucket and update the mirror like the table does.
  function automatic dedup_rsp_t resolve_request(input dedup_req_t req);
    dedup_rsp_t  rsp;
    logic [7:0]  bucket;
    int unsigned home;
    int unsigned s;
    logic        done;
    rsp = '0;
    rsp.status = STAT_MISS;
    done = 1'b0;
    bucket = req.digest[0][7:0] ^ req.digest[0][15:8] ^ req.digest[0][23:16] ^
             req.digest[0][31:24];
    home = int'(bucket) % TABLE_ENTRIES;
    case (req.func)
      FUNC_LOOKUP: begin
        for (int unsigned k = 0; k < TABLE_ENTRIES; k++) begin
          s = (home + k) % TABLE_ENTRIES;
          if (!done && slot_valid[s] && slot_digest[s] == req.digest) begin
            rsp.status = STAT_HIT;
            rsp.id_hi  = slot_id_hi[s];
            rsp.id_lo  = slot_id_lo[s];
            rsp.slot   = s[SLOT_W-1:0];
            done = 1'b1;
          end
        end
      end
      FUNC_INSERT: begin
        rsp.status = STAT_FULL;
        for (int unsigned k = 0; k < TABLE_ENTRIES; k++) begin
          s = (home + k) % TABLE_ENTRIES;
          if (!done && !slot_valid[s]) begin
            slot_valid[s]  = 1'b1;
            slot_digest[s] = req.digest;
            slot_id_hi[s]  = req.id_hi;
            slot_id_lo[s]  = req.id_lo;
            rsp.status = STAT_INSERTED;
            rsp.slot   = s[SLOT_W-1:0];
            done = 1'b1;
          end
        end
      end
      FUNC_CLEAR: begin
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        rsp.status = STAT_CLEARED;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic queue_request(input logic [FUNC_W-1:0] fn, input digest_t digest,
                               input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] lo);
    dedup_req_t req;
    req.func   = fn;
    req.digest = digest;
    req.id_hi  = hi;
    req.id_lo  = lo;
    pending_q.push_back(req);
    if (fn == FUNC_INSERT) begin
      inserts_since_clear++;
      digest_pool.push_back(digest);
    end
    if (fn == FUNC_CLEAR) inserts_since_clear = 0;
  endtask

  function automatic digest_t fresh_digest();
    digest_t d;
    d = {rand64(), rand64(), rand64(), rand64()};
    // crowd some keys onto the buckets just below the wrap point
    if ($urandom_range(0, 99) < 30) d[0][31:0] = {24'h0, 8'($urandom_range(248, 255))};
    return d;
  endfunction

  task automatic queue_random_request(input int unsigned insert_pct,
                                      input int unsigned clear_pct);
    int unsigned pick;
    int unsigned flavor;
    digest_t     d;
    pick   = $urandom_range(0, 99);
    flavor = $urandom_range(0, 99);
    d = fresh_digest();
    if (pick < clear_pct) begin
      queue_request(FUNC_CLEAR, d, rand64(), rand64());
    end else if (pick < clear_pct + 1) begin
      queue_request(FUNC_UNUSED, d, rand64(), rand64());
    end else if (pick < clear_pct + 1 + insert_pct) begin
      // duplicate keys land in a second slot
      if (flavor < 15 && digest_pool.size() != 0)
        d = digest_pool[$urandom_range(0, digest_pool.size() - 1)];
      queue_request(FUNC_INSERT, d, rand64(), rand64());
    end else begin
      if (flavor < 85 && digest_pool.size() != 0) begin
        d = digest_pool[$urandom_range(0, digest_pool.size() - 1)];
        // one flipped bit must miss
        if (flavor >= 60) d = d ^ (digest_t'(1) << $urandom_range(0, 255));
      end
      queue_request(FUNC_LOOKUP, d, rand64(), rand64());
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      func_i       <= '0;
      hash_word0_i <= '0;
      hash_word1_i <= '0;
      hash_word2_i <= '0;
      hash_word3_i <= '0;
      id_high_i    <= '0;
      id_low_i     <= '0;
      send_idle    <= 0;
      tail_phase   <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        taken_req.func   = func_i;
        taken_req.digest = {hash_word3_i, hash_word2_i, hash_word1_i, hash_word0_i};
        taken_req.id_hi  = id_high_i;
        taken_req.id_lo  = id_low_i;
        lookup_answers_q.push_back(resolve_request(taken_req));
      end
      tail_phase <= (pending_q.size() < TAIL_ITEMS);
      if (!in_valid_i || in_ready_o) begin
        if (send_idle != 0) begin
          in_valid_i <= 1'b0;
          send_idle  <= send_idle - 1;
        end else if (pending_q.size() != 0 && !tail_phase && $urandom_range(0, 99) < 6) begin
          in_valid_i <= 1'b0;
          send_idle  <= $urandom_range(0, 16);
        end else if (pending_q.size() != 0) begin
          taken_req = pending_q.pop_front();
          in_valid_i   <= 1'b1;
          func_i       <= taken_req.func;
          hash_word0_i <= taken_req.digest[0];
          hash_word1_i <= taken_req.digest[1];
          hash_word2_i <= taken_req.digest[2];
          hash_word3_i <= taken_req.digest[3];
          id_high_i    <= taken_req.id_hi;
          id_low_i     <= taken_req.id_lo;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_rsp = {status_o, found_id_high_o, found_id_low_o, slot_index_o};
        if (lookup_answers_q.size() == 0) begin
          $error("result transfer with nothing pending: status %0d", got_rsp.status);
          mismatches++;
        end else begin
          want_rsp = lookup_answers_q.pop_front();
          if (got_rsp.status !== want_rsp.status) begin
            $error("status: expected %0d, got %0d", want_rsp.status, got_rsp.status);
            mismatches++;
          end
          if (got_rsp.id_hi !== want_rsp.id_hi) begin
            $error("found_id_high: expected %h, got %h", want_rsp.id_hi, got_rsp.id_hi);
            mismatches++;
          end
          if (got_rsp.id_lo !== want_rsp.id_lo) begin
            $error("found_id_low: expected %h, got %h", want_rsp.id_lo, got_rsp.id_lo);
            mismatches++;
          end
          if (got_rsp.slot !== want_rsp.slot) begin
            $error("slot_index: expected %0d, got %0d", want_rsp.slot, got_rsp.slot);
            mismatches++;
          end
        end
      end
      if (recv_stall != 0) begin
        out_ready_i <= 1'b0;
        recv_stall  <= recv_stall - 1;
      end else if (!tail_phase && $urandom_range(0, 99) < 6) begin
        out_ready_i <= 1'b0;
        recv_stall  <= $urandom_range(0, 16);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    digest_t ones;
    digest_t zeros;
    digest_t wrap_a;
    digest_t wrap_b;
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    ones   = '1;
    zeros  = '0;
    wrap_a = {rand64(), rand64(), rand64(), 64'h0000_0000_0000_00ff};
    wrap_b = {rand64(), rand64(), rand64(), 64'h0000_0001_0000_00ff};

    queue_request(FUNC_LOOKUP, ones, '1, '1);
    queue_request(FUNC_UNUSED, ones, '1, '1);
    queue_request(FUNC_INSERT, zeros, '1, '1);
    queue_request(FUNC_INSERT, ones, '0, '0);
    queue_request(FUNC_LOOKUP, zeros, '0, '0);
    queue_request(FUNC_LOOKUP, ones, '0, '0);
    queue_request(FUNC_INSERT, wrap_a, rand64(), rand64());
    // same home bucket, wraps past the top slot
    queue_request(FUNC_INSERT, wrap_b, rand64(), rand64());
    queue_request(FUNC_LOOKUP, wrap_b, '0, '0);
    queue_request(FUNC_INSERT, wrap_a, rand64(), rand64());
    queue_request(FUNC_LOOKUP, wrap_a, '0, '0);
    queue_request(FUNC_LOOKUP, wrap_a ^ {1'b1, 255'b0}, '0, '0);
    queue_request(FUNC_CLEAR, zeros, '0, '0);
    queue_request(FUNC_LOOKUP, wrap_a, '0, '0);
    queue_request(FUNC_INSERT, wrap_a, rand64(), rand64());
    queue_request(FUNC_LOOKUP, wrap_a, '0, '0);
    queue_request(FUNC_LOOKUP, zeros, '0, '0);
    queue_request(FUNC_CLEAR, ones, '1, '1);

    // fill past capacity so the last inserts are dropped
    while (inserts_since_clear < TABLE_ENTRIES + 6) queue_random_request(70, 0);
    repeat (120) queue_random_request(10, 0);
    queue_request(FUNC_CLEAR, fresh_digest(), rand64(), rand64());
    repeat (110) queue_random_request(40, 4);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (lookup_answers_q.size() != 0) @(posedge clk_i);
    repeat (TABLE_ENTRIES + 16) @(posedge clk_i);
    if (mismatches == 0 && lookup_answers_q.size() == 0) begin
      $display("dedup_hash_table_core: match");
    end else begin
      $display("dedup_hash_table_core: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("dedup_hash_table_core: mismatch");
    $finish;
  end

endmodule
